[rtl/shift_invariant_state_hash_compare_macros.svh]
// Assertion macros for the shift-invariant state hash block.
// Included by sishc_seq.sv, the RTL file that carries concurrent checks; no dependencies.
`ifndef SHIFT_INVARIANT_STATE_HASH_COMPARE_MACROS_SVH
`define SHIFT_INVARIANT_STATE_HASH_COMPARE_MACROS_SVH

`ifndef SYNTH

// antecedent holds -> consequent holds in the same cycle
`define SISHC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sishc check failed");

// antecedent holds -> consequent holds in the next cycle
`define SISHC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sishc check failed");

`else

`define SISHC_ASSERT_SAME(label, clk, rstn, ante, cons)
`define SISHC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[rtl/sishc_pkg.sv]
// Shared types, constants and helpers of the shift-invariant state hash block.
// No dependencies; used by sishc_mac, sishc_seq and the top level.
package sishc_pkg;

    localparam int COORD_BITS = 16;
    localparam int FIELD_W    = 16;
    localparam int ORIENT_W   = 8;
    localparam int OFS_W      = COORD_BITS + 1;
    localparam int HASH_W     = 32;
    localparam int MUL_W      = 11;

    localparam logic [HASH_W-1:0] HASH_START = 32'h17fe3b3c;
    localparam logic [MUL_W-1:0]  MUL_X      = 11'd1343;
    localparam logic [MUL_W-1:0]  MUL_Y      = 11'd923;
    localparam logic [MUL_W-1:0]  MUL_Z      = 11'd113;
    localparam logic [MUL_W-1:0]  MUL_O      = 11'd23;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        STEP_X = 2'd0,
        STEP_Y = 2'd1,
        STEP_Z = 2'd2,
        STEP_O = 2'd3
    } step_t;

    typedef struct packed {
        logic  accept;
        logic  first;
        logic  mac_en;
        step_t step;
        logic  emit;
    } ctrl_t;

    typedef logic [COORD_BITS-1:0] coord_t;

    // signed offset of two COORD_BITS values, sign-extended to the hash width
    function automatic logic [HASH_W-1:0] rel_ofs(input coord_t pos, input coord_t ref_pos);
        logic signed [COORD_BITS-1:0] p;
        logic signed [COORD_BITS-1:0] r;
        logic signed [OFS_W-1:0]      d;
        p = $signed(pos);
        r = $signed(ref_pos);
        d = OFS_W'(p) - OFS_W'(r);
        return HASH_W'(d);
    endfunction

    function automatic logic [MUL_W-1:0] step_mul(input step_t s);
        logic [MUL_W-1:0] m;
        unique case (s)
            STEP_X:  m = MUL_X;
            STEP_Y:  m = MUL_Y;
            STEP_Z:  m = MUL_Z;
            STEP_O:  m = MUL_O;
            default: m = MUL_O;
        endcase
        return m;
    endfunction

endpackage

[rtl/shift_invariant_state_hash_compare.sv]
// Channel | dir | payload
// s_      | in  | one piece of states A and B; tuser = first_piece, tlast = last_piece
// m_      | out | state_hash and states_equal, on a last_piece request only
//
// A reference piece is only accepted; a later piece is accepted and then makes
// four passes through the shared multiply-add unit, one per hash term.
// A result is then loaded into the output register; that load waits while
// the register still holds an untaken result. s_tready is low while working.
// Synchronous active-low reset clears references, hash to 0 and match to 1.
// Top level; depends on sishc_pkg, sishc_seq, sishc_mac.
module shift_invariant_state_hash_compare (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_x, a_y, a_z, a_orient, b_x, b_y, b_z, b_orient
    input  logic [111:0] s_tdata,
    // first_piece
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // state_hash, states_equal, zero pad
    output logic [39:0]  m_tdata
);

    localparam int AO_LSB = 3 * sishc_pkg::FIELD_W;
    localparam int B_LSB  = AO_LSB + sishc_pkg::ORIENT_W;
    localparam int BO_LSB = B_LSB + 3 * sishc_pkg::FIELD_W;

    sishc_pkg::ctrl_t ctrl;
    logic             out_free;

    sishc_pkg::coord_t ref_a_reg [3];
    sishc_pkg::coord_t ref_b_reg [3];
    sishc_pkg::coord_t pos_a_reg [3];
    sishc_pkg::coord_t pos_b_reg [3];
    logic [sishc_pkg::ORIENT_W-1:0] ori_a_reg, ori_b_reg;
    logic [sishc_pkg::HASH_W-1:0]   hash_reg, hash_next;
    logic                           match_reg, match_next;

    logic [sishc_pkg::HASH_W-1:0] out_hash_reg;
    logic                         out_eq_reg;
    logic                         m_tvalid_reg, m_tvalid_next;

    logic [sishc_pkg::ORIENT_W-1:0] in_ao, in_bo;
    logic [sishc_pkg::HASH_W-1:0]   da, db, addend, mac_out;
    logic [1:0]                     idx;

    assign in_ao = s_tdata[AO_LSB +: sishc_pkg::ORIENT_W];
    assign in_bo = s_tdata[BO_LSB +: sishc_pkg::ORIENT_W];

    sishc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_first  (s_tuser),
        .s_last   (s_tlast),
        .out_free (out_free),
        .s_tready (s_tready),
        .ctrl     (ctrl)
    );

    assign idx = ctrl.step;
    assign da  = sishc_pkg::rel_ofs(pos_a_reg[idx], ref_a_reg[idx]);
    assign db  = sishc_pkg::rel_ofs(pos_b_reg[idx], ref_b_reg[idx]);

    always_comb begin
        if (ctrl.step == sishc_pkg::STEP_O) begin
            addend = sishc_pkg::HASH_W'(ori_a_reg);
        end else begin
            addend = da;
        end
    end

    sishc_mac u_mac (
        .hash_in  (hash_reg),
        .addend   (addend),
        .mult     (sishc_pkg::step_mul(ctrl.step)),
        .hash_out (mac_out)
    );

    always_comb begin
        hash_next  = hash_reg;
        match_next = match_reg;
        if (ctrl.accept && ctrl.first) begin
            hash_next  = sishc_pkg::HASH_START + sishc_pkg::HASH_W'(in_ao);
            match_next = (in_ao == in_bo);
        end else if (ctrl.mac_en) begin
            hash_next = mac_out;
            if (ctrl.step == sishc_pkg::STEP_O) begin
                if (ori_a_reg != ori_b_reg) begin
                    match_next = 1'b0;
                end
            end else if (da != db) begin
                match_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                ref_a_reg[i] <= '0;
                ref_b_reg[i] <= '0;
            end
            hash_reg  <= '0;
            match_reg <= 1'b1;
        end else begin
            hash_reg  <= hash_next;
            match_reg <= match_next;
            if (ctrl.accept && ctrl.first) begin
                for (int i = 0; i < 3; i++) begin
                    ref_a_reg[i] <= s_tdata[i*sishc_pkg::FIELD_W +: sishc_pkg::COORD_BITS];
                    ref_b_reg[i] <= s_tdata[B_LSB + i*sishc_pkg::FIELD_W +: sishc_pkg::COORD_BITS];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.accept && !ctrl.first) begin
            for (int i = 0; i < 3; i++) begin
                pos_a_reg[i] <= s_tdata[i*sishc_pkg::FIELD_W +: sishc_pkg::COORD_BITS];
                pos_b_reg[i] <= s_tdata[B_LSB + i*sishc_pkg::FIELD_W +: sishc_pkg::COORD_BITS];
            end
            ori_a_reg <= in_ao;
            ori_b_reg <= in_bo;
        end
    end

    // output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (ctrl.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            out_hash_reg <= (hash_reg == '0) ? sishc_pkg::HASH_W'(1) : hash_reg;
            out_eq_reg   <= match_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_eq_reg, out_hash_reg};

endmodule

[rtl/sishc_mac.sv]
// Shared add-then-multiply unit: hash = (hash + addend) * mult, mod 2^32.
// Depends on sishc_pkg.
module sishc_mac (
    input  logic [sishc_pkg::HASH_W-1:0] hash_in,
    input  logic [sishc_pkg::HASH_W-1:0] addend,
    input  logic [sishc_pkg::MUL_W-1:0]  mult,
    output logic [sishc_pkg::HASH_W-1:0] hash_out
);

    logic [sishc_pkg::HASH_W-1:0] sum;

    assign sum      = hash_in + addend;
    assign hash_out = sum * sishc_pkg::HASH_W'(mult);

endmodule

[rtl/sishc_seq.sv]
// Sequencer: accepts a request, steps the shared multiply-add unit four times if
// not first, loads the result register if last. Depends on sishc_pkg, macros header.
`include "shift_invariant_state_hash_compare_macros.svh"

module sishc_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_first,
    input  logic              s_last,
    input  logic              out_free,
    output logic              s_tready,
    output sishc_pkg::ctrl_t  ctrl
);

    sishc_pkg::state_t state_reg, state_next;
    sishc_pkg::step_t  step_reg, step_next;
    logic              last_reg, last_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sishc_pkg::ST_IDLE;
            step_reg  <= sishc_pkg::STEP_X;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sishc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (!s_first) begin
                        state_next = sishc_pkg::ST_STEP;
                    end else if (s_last) begin
                        state_next = sishc_pkg::ST_EMIT;
                    end
                end
            end
            sishc_pkg::ST_STEP: begin
                if (step_reg == sishc_pkg::STEP_O) begin
                    state_next = last_reg ? sishc_pkg::ST_EMIT : sishc_pkg::ST_IDLE;
                end
            end
            sishc_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = sishc_pkg::ST_IDLE;
                end
            end
            default: state_next = sishc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready    = (state_reg == sishc_pkg::ST_IDLE);
        ctrl.accept = (state_reg == sishc_pkg::ST_IDLE) && s_tvalid;
        ctrl.first  = s_first;
        ctrl.mac_en = (state_reg == sishc_pkg::ST_STEP);
        ctrl.step   = step_reg;
        ctrl.emit   = (state_reg == sishc_pkg::ST_EMIT) && out_free;
    end

    always_comb begin
        step_next = step_reg;
        last_next = last_reg;
        if (ctrl.accept) begin
            step_next = sishc_pkg::STEP_X;
            last_next = s_last;
        end else if (ctrl.mac_en) begin
            step_next = sishc_pkg::step_t'(step_reg + 2'd1);
        end
    end

    `SISHC_ASSERT_NEXT(a_later_starts_steps, aclk, aresetn, ctrl.accept && !s_first, state_reg == sishc_pkg::ST_STEP && step_reg == sishc_pkg::STEP_X)
    `SISHC_ASSERT_NEXT(a_single_emits, aclk, aresetn, ctrl.accept && s_first && s_last, state_reg == sishc_pkg::ST_EMIT)
    `SISHC_ASSERT_NEXT(a_steps_end, aclk, aresetn, ctrl.mac_en && step_reg == sishc_pkg::STEP_O, state_reg != sishc_pkg::ST_STEP)
    `SISHC_ASSERT_NEXT(a_emit_done, aclk, aresetn, ctrl.emit, state_reg == sishc_pkg::ST_IDLE)

endmodule
